// ----- design/error_diffusion_dither_macros.svh -----
// Assertion macros for the error diffusion dither block.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef ERROR_DIFFUSION_DITHER_MACROS_SVH
`define ERROR_DIFFUSION_DITHER_MACROS_SVH

// checked only outside reset
`define EDD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// checked on every edge, reset included
`define EDD_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- design/ed_dither_pkg.sv -----
// Shared constants and word types of the error diffusion dither block.
// No dependencies; used by the channel interfaces and the top level.
package ed_dither_pkg;

  localparam int unsigned MaxWidth   = 2048;
  localparam int unsigned ColW       = $clog2(MaxWidth);
  localparam int unsigned LevelBits  = 6;
  localparam int unsigned ChanW      = 8;
  localparam int unsigned WidthRegW  = 12;
  localparam int unsigned HeightRegW = 16;
  localparam int unsigned CfgDataW   = 16;

  typedef enum logic {
    CfgImageWidth  = 1'b0,
    CfgImageHeight = 1'b1
  } cfg_reg_e;

  typedef logic [ChanW-1:0] chan_t;

  typedef struct packed {
    chan_t red_in;
    chan_t green_in;
    chan_t blue_in;
    chan_t alpha_in;
  } in_word_t;

  typedef struct packed {
    chan_t red_out;
    chan_t green_out;
    chan_t blue_out;
    chan_t alpha_out;
    logic  row_end;
    logic  frame_end;
  } out_word_t;

  typedef struct packed {
    chan_t r;
    chan_t g;
    chan_t b;
  } err_t;

endpackage

// ----- design/ed_dither_if.sv -----
// Valid/ready channel interfaces for pixel words in and dithered words out.
// Depends on ed_dither_pkg for the word types.
interface ed_dither_in_if;
  import ed_dither_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ed_dither_out_if;
  import ed_dither_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/error_diffusion_dither.sv -----
// Top level of the error diffusion dither: line buffer, diffusion stage, output register.
// Depends on ed_dither_pkg, ed_dither_if.sv and error_diffusion_dither_macros.svh.
//
//   port      dir   word         handshake
//   pix_i     in    in_word_t    valid/ready
//   pix_o     out   out_word_t   valid/ready
//   cfg_*     in    16-bit data  write enable, no ready
//
// One word per clock sustained while pix_o is ready; a word passes the stage register, then the output register.
// The line buffer is read as a word is taken and written by the diffusion stage as
// that word leaves it; the right-hand error loops back inside that stage through rc_q.
// Reset is asynchronous; the line buffer is not cleared (first row reads no error).
// A stall at pix_o holds the diffusion stage and then the input.
`include "error_diffusion_dither_macros.svh"

module error_diffusion_dither (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  ed_dither_pkg::cfg_reg_e              cfg_idx_i,
  input  logic [ed_dither_pkg::CfgDataW-1:0]   cfg_wdata_i,
  ed_dither_in_if.sink                         pix_i,
  ed_dither_out_if.source                      pix_o
);
  import ed_dither_pkg::*;

  localparam int unsigned WCmpW = (ColW + 1 > WidthRegW) ? ColW + 1 : WidthRegW;

  typedef struct packed {
    in_word_t        pix;
    logic [ColW-1:0] col;
    logic            first_col;
    logic            first_row;
    logic            last_col;
    logic            last_row;
  } s1_t;

  typedef struct packed {
    chan_t q;
    chan_t rc;
    chan_t blw;
    chan_t cur;
    chan_t bp;
  } chan_res_t;

  function automatic chan_res_t diffuse(chan_t pix, chan_t rc, chan_t err, chan_t bl,
                                        chan_t bp);
    logic [ChanW+1:0]     sum;
    logic [LevelBits-1:0] rem;
    logic [LevelBits+2:0] m7;
    logic [LevelBits+2:0] m3;
    logic [LevelBits+2:0] m5;
    chan_res_t            res;
    sum = {2'b00, pix} + {2'b00, rc} + {2'b00, err};
    rem = sum[LevelBits-1:0];
    m7  = (LevelBits+3)'(rem) * (LevelBits+3)'(7);
    m3  = (LevelBits+3)'(rem) * (LevelBits+3)'(3);
    m5  = (LevelBits+3)'(rem) * (LevelBits+3)'(5);
    res.q   = (sum[ChanW+1:ChanW] != 2'b00) ? '1
            : {sum[ChanW-1:LevelBits], {LevelBits{1'b0}}};
    res.rc  = ChanW'(m7 >> 4);
    res.blw = bl + ChanW'(m3 >> 4);
    res.cur = bp + ChanW'(m5 >> 4);
    res.bp  = ChanW'(rem >> 4);
    return res;
  endfunction

  logic [WidthRegW-1:0]  width_q;
  logic [HeightRegW-1:0] height_q;
  logic [WCmpW-1:0]      width_eff;
  logic [HeightRegW-1:0] height_eff;
  logic [ColW-1:0]       col_q;
  logic [HeightRegW-1:0] row_q;
  logic                  last_col;
  logic                  last_row;
  logic                  accept;

  s1_t       s1_q;
  logic      s1_v_q;
  logic      s1_fire;
  err_t      rdata_q;
  err_t      fwd_q;
  logic      fwd_v_q;
  err_t      pend_q;
  logic [ColW-1:0] pend_addr_q;
  logic      pend_v_q;
  err_t      rc_q;
  err_t      bl_q;
  err_t      bp_q;
  logic      out_v_q;
  out_word_t out_q;

  err_t      mem [MaxWidth];

  logic            main_we;
  logic            flush_we;
  logic            wr_en;
  logic [ColW-1:0] wr_addr;
  err_t            wr_data;
  err_t            err_raw;
  err_t            err_use;
  err_t            rc_use;
  err_t            blw_all;
  err_t            cur_all;
  chan_res_t       res_r;
  chan_res_t       res_g;
  chan_res_t       res_b;

  // frame geometry
  always_comb begin
    if (width_q == '0) begin
      width_eff = WCmpW'(1);
    end else if (WCmpW'(width_q) > WCmpW'(MaxWidth)) begin
      width_eff = WCmpW'(MaxWidth);
    end else begin
      width_eff = WCmpW'(width_q);
    end
    height_eff = (height_q == '0) ? HeightRegW'(1) : height_q;
  end

  assign last_col = (WCmpW'(col_q) + WCmpW'(1)) >= width_eff;
  assign last_row = ({1'b0, row_q} + (HeightRegW+1)'(1)) >= {1'b0, height_eff};

  assign s1_fire     = s1_v_q && (!out_v_q || pix_o.ready);
  assign pix_i.ready = !s1_v_q || s1_fire;
  assign accept      = pix_i.valid && pix_i.ready;

  // line buffer write port: left-below write wins, last-column write waits in pend_q until the port is free
  assign main_we  = s1_fire && !s1_q.first_col && !s1_q.last_row;
  assign flush_we = pend_v_q && !main_we;
  assign wr_en    = main_we || flush_we;
  assign wr_addr  = main_we ? s1_q.col - ColW'(1) : pend_addr_q;
  assign wr_data  = main_we ? blw_all : pend_q;

  always_comb begin
    if (flush_we && pend_addr_q == s1_q.col) begin
      err_raw = pend_q;
    end else if (fwd_v_q) begin
      err_raw = fwd_q;
    end else begin
      err_raw = rdata_q;
    end
    err_use = s1_q.first_row ? '0 : err_raw;
    rc_use  = s1_q.first_col ? '0 : rc_q;
    res_r   = diffuse(s1_q.pix.red_in, rc_use.r, err_use.r, bl_q.r, bp_q.r);
    res_g   = diffuse(s1_q.pix.green_in, rc_use.g, err_use.g, bl_q.g, bp_q.g);
    res_b   = diffuse(s1_q.pix.blue_in, rc_use.b, err_use.b, bl_q.b, bp_q.b);
    blw_all = '{r: res_r.blw, g: res_g.blw, b: res_b.blw};
    cur_all = '{r: res_r.cur, g: res_g.cur, b: res_b.cur};
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (accept) begin
      rdata_q <= mem[col_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthRegW'(640);
      height_q <= HeightRegW'(480);
      col_q    <= '0;
      row_q    <= '0;
      s1_v_q   <= 1'b0;
      fwd_v_q  <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      rc_q     <= '0;
      bl_q     <= '0;
      bp_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgImageWidth:  width_q  <= cfg_wdata_i[WidthRegW-1:0];
          CfgImageHeight: height_q <= cfg_wdata_i[HeightRegW-1:0];
        endcase
      end

      if (accept) begin
        if (last_col) begin
          col_q <= '0;
          row_q <= last_row ? '0 : row_q + HeightRegW'(1);
        end else begin
          col_q <= col_q + ColW'(1);
        end
        s1_v_q  <= 1'b1;
        fwd_v_q <= wr_en && (wr_addr == col_q);
      end else begin
        if (s1_fire) begin
          s1_v_q <= 1'b0;
        end
        if (s1_v_q && wr_en && wr_addr == s1_q.col) begin
          fwd_v_q <= 1'b1;
        end
      end

      if (s1_fire) begin
        rc_q <= s1_q.last_col ? '0 : err_t'{r: res_r.rc, g: res_g.rc, b: res_b.rc};
        if (s1_q.last_col) begin
          bl_q <= '0;
          bp_q <= '0;
        end else if (!s1_q.last_row) begin
          bl_q <= cur_all;
          bp_q <= '{r: res_r.bp, g: res_g.bp, b: res_b.bp};
        end
      end

      if (s1_fire && s1_q.last_col && !s1_q.last_row) begin
        pend_v_q <= 1'b1;
      end else if (flush_we) begin
        pend_v_q <= 1'b0;
      end

      if (s1_fire) begin
        out_v_q <= 1'b1;
      end else if (pix_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q.pix       <= pix_i.data;
      s1_q.col       <= col_q;
      s1_q.first_col <= (col_q == '0);
      s1_q.first_row <= (row_q == '0);
      s1_q.last_col  <= last_col;
      s1_q.last_row  <= last_row;
      fwd_q          <= wr_data;
    end else if (s1_v_q && wr_en && wr_addr == s1_q.col) begin
      fwd_q <= wr_data;
    end
    if (s1_fire && s1_q.last_col && !s1_q.last_row) begin
      pend_q      <= cur_all;
      pend_addr_q <= s1_q.col;
    end
    if (s1_fire) begin
      out_q.red_out   <= res_r.q;
      out_q.green_out <= res_g.q;
      out_q.blue_out  <= res_b.q;
      out_q.alpha_out <= s1_q.pix.alpha_in;
      out_q.row_end   <= s1_q.last_col;
      out_q.frame_end <= s1_q.last_col && s1_q.last_row;
    end
  end

  assign pix_o.valid = out_v_q;
  assign pix_o.data  = out_q;

  `EDD_ASSERT(a_wr_not_own_col, main_we |-> (wr_addr != s1_q.col), "write hits column in use")
  `EDD_ASSERT(a_frame_end_row, out_v_q && out_q.frame_end |-> out_q.row_end, "frame end mid-row")
  `EDD_ASSERT(a_pend_set, s1_fire && s1_q.last_col && !s1_q.last_row |=> pend_v_q, "lost write")
  `EDD_ASSERT_ALWAYS(a_ready_empty, !s1_v_q |-> pix_i.ready, "input stalled while empty")

endmodule
